// File: rtl/assert_macros.svh
// Assertion macros shared by the cache RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// File: rtl/dmdc_pkg.sv
// Shared types and constants for the direct-mapped data cache.
// No dependencies.
package dmdc_pkg;
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_STORE = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;
	localparam logic [1:0] SZ_WORD = 2'd2;
	localparam logic [1:0] SZ_DBL  = 2'd3;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam int TAG_W = 20;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_WB_RD,
		ST_WB_EMIT,
		ST_REQ,
		ST_WAIT_FILL,
		ST_FILL_WR,
		ST_FIN_RD,
		ST_FIN_WR,
		ST_LOAD_RD,
		ST_LOAD_EMIT
	} state_t;

	// critical doubleword first
	function automatic logic [1:0] seq_word(input logic crit, input logic [1:0] p);
		seq_word = {p[1] ^ crit, p[0]};
	endfunction

	// merge store data into a word pair (hi word, lo word)
	function automatic logic [63:0] merge(input logic [63:0] old, input logic [1:0] size,
			input logic [2:0] a, input logic [63:0] v);
		logic [31:0] w;
		logic [63:0] r;
		logic [4:0] sh;
		r = old;
		w = a[2] ? old[31:0] : old[63:32];
		sh = '0;
		case (size)
			SZ_BYTE: begin
				sh = {~a[1:0], 3'b000};
				w = (w & ~(32'hff << sh)) | ({24'd0, v[7:0]} << sh);
			end
			SZ_HALF: begin
				sh = {~a[1], 4'b0000};
				w = (w & ~(32'hffff << sh)) | ({16'd0, v[15:0]} << sh);
			end
			SZ_WORD: w = v[31:0];
			default: w = w;
		endcase
		if (size == SZ_DBL) r = v;
		else if (a[2]) r[31:0] = w;
		else r[63:32] = w;
		merge = r;
	endfunction

	function automatic logic [63:0] extract(input logic [63:0] pair, input logic [1:0] size,
			input logic [2:0] a);
		logic [31:0] w;
		logic [31:0] t;
		w = a[2] ? pair[31:0] : pair[63:32];
		t = '0;
		case (size)
			SZ_BYTE: begin
				t = w >> {~a[1:0], 3'b000};
				extract = {56'd0, t[7:0]};
			end
			SZ_HALF: begin
				t = w >> {~a[1], 4'b0000};
				extract = {48'd0, t[15:0]};
			end
			SZ_WORD: extract = {32'd0, w};
			default: extract = pair;
		endcase
	endfunction
endpackage

// File: rtl/dmdc_data_ram.sv
// Line data store: one row per doubleword pair of words (hi, lo).
// Depends on nothing; synchronous, registered read.
module dmdc_data_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/dmdc_tag_ram.sv
// Tag store: valid, dirty and tag per line.
// Depends on nothing; synchronous, registered read.
module dmdc_tag_ram #(
	parameter int DEPTH = 512,
	parameter int AW = 9,
	parameter int W = 22
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/direct_mapped_writeback_dcache_top.sv
// Direct-mapped write-back data cache: a one-at-a-time sequencer over a
// tag store and a data store. Depends on dmdc_pkg, dmdc_tag_ram, dmdc_data_ram.
//
// Each item is handled on its own. A hit load does the lookup, a data read and
// an emit; a hit store the lookup, a read and a merged write. A miss does the
// lookup, then, if the victim is dirty, a read and two word emits per pair of
// write-back words, then the read requests, held while the output stalls. Each
// fill is taken, then written. After the last fill a store reads and merges, a
// load reads and emits its result. The single read port of each memory and the
// read-modify-write of a word pair set these steps. After reset a clearing pass
// sweeps every tag store line before the first item is accepted. Result items
// leave through an output register that holds while the consumer stalls.
`include "assert_macros.svh"
module direct_mapped_writeback_dcache_top #(
	parameter int LINE_COUNT = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [1:0]  access_size,
	input  logic [31:0] address,
	input  logic [63:0] store_value,
	input  logic [31:0] fill_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] bus_address,
	output logic [31:0] bus_word,
	output logic [63:0] load_value,
	output logic        last
);
	localparam int LW = $clog2(LINE_COUNT);
	localparam int TW = dmdc_pkg::TAG_W + 2;

	dmdc_pkg::state_t state_q, state_d;

	// pending request
	logic [1:0]  op_q, size_q;
	logic [31:0] addr_q;
	logic [63:0] sv_q;
	logic [2:0]  fills_q;
	logic [1:0]  pos_q;
	logic [1:0]  cnt_q;
	logic [LW-1:0] clr_q;
	logic [dmdc_pkg::TAG_W-1:0] old_tag_q;
	logic [31:0] fw_q;
	logic        pend_q;

	logic [LW-1:0] line;
	assign line = addr_q[LW+3:4];

	// memory ports
	logic tag_we;
	logic [LW-1:0] tag_wa, tag_ra;
	logic [TW-1:0] tag_wd, tag_rd;
	logic dat_we;
	logic [LW:0] dat_wa, dat_ra;
	logic [63:0] dat_wd, dat_rd;

	dmdc_tag_ram #(.DEPTH(LINE_COUNT), .AW(LW), .W(TW)) u_tag (
		.clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
		.raddr(tag_ra), .rdata(tag_rd)
	);
	dmdc_data_ram #(.DEPTH(2*LINE_COUNT), .AW(LW+1)) u_dat (
		.clk(clk), .we(dat_we), .waddr(dat_wa), .wdata(dat_wd),
		.raddr(dat_ra), .rdata(dat_rd)
	);

	logic t_valid, t_dirty;
	logic [dmdc_pkg::TAG_W-1:0] t_tag;
	assign t_valid = tag_rd[TW-1];
	assign t_dirty = tag_rd[TW-2];
	assign t_tag = tag_rd[dmdc_pkg::TAG_W-1:0];

	logic hit;
	assign hit = t_valid && (t_tag == addr_q[31:12]);

	logic obuf_free;
	assign obuf_free = !out_valid || out_ready;
	assign in_ready = (state_q == dmdc_pkg::ST_IDLE) || (state_q == dmdc_pkg::ST_WAIT_FILL);

	logic acc;
	assign acc = in_valid && in_ready;

	logic is_dbl_store;
	assign is_dbl_store = (op_q == dmdc_pkg::OP_STORE) && (size_q == dmdc_pkg::SZ_DBL);

	// fill position and word
	logic [1:0] fpos, fword;
	assign fpos = is_dbl_store ? {1'b1, fills_q[0]} : 2'(3'd4 - fills_q);
	assign fword = dmdc_pkg::seq_word(addr_q[3], fpos);

	logic [1:0] rq_word;
	assign rq_word = dmdc_pkg::seq_word(addr_q[3], pos_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dmdc_pkg::ST_CLEAR: if (clr_q == LW'(LINE_COUNT - 1)) state_d = dmdc_pkg::ST_IDLE;
			dmdc_pkg::ST_IDLE: begin
				if (acc && (opcode == dmdc_pkg::OP_LOAD || opcode == dmdc_pkg::OP_STORE))
					state_d = dmdc_pkg::ST_LOOKUP;
			end
			dmdc_pkg::ST_LOOKUP: begin
				if (hit) state_d = (op_q == dmdc_pkg::OP_LOAD) ? dmdc_pkg::ST_LOAD_RD
					: dmdc_pkg::ST_FIN_RD;
				else if (t_dirty) state_d = dmdc_pkg::ST_WB_RD;
				else state_d = dmdc_pkg::ST_REQ;
			end
			dmdc_pkg::ST_WB_RD: state_d = dmdc_pkg::ST_WB_EMIT;
			dmdc_pkg::ST_WB_EMIT: begin
				if (obuf_free && cnt_q[0]) state_d = (cnt_q == 2'd3) ? dmdc_pkg::ST_REQ
					: dmdc_pkg::ST_WB_RD;
			end
			dmdc_pkg::ST_REQ: if (obuf_free && pos_q == 2'd3) state_d = dmdc_pkg::ST_WAIT_FILL;
			dmdc_pkg::ST_WAIT_FILL: if (acc && opcode == dmdc_pkg::OP_FILL)
				state_d = dmdc_pkg::ST_FILL_WR;
			dmdc_pkg::ST_FILL_WR: state_d = (fills_q == 3'd1) ? dmdc_pkg::ST_FIN_RD
				: dmdc_pkg::ST_WAIT_FILL;
			dmdc_pkg::ST_FIN_RD: state_d = (op_q == dmdc_pkg::OP_LOAD) ? dmdc_pkg::ST_LOAD_EMIT
				: dmdc_pkg::ST_FIN_WR;
			dmdc_pkg::ST_FIN_WR: state_d = dmdc_pkg::ST_IDLE;
			dmdc_pkg::ST_LOAD_RD: state_d = dmdc_pkg::ST_LOAD_EMIT;
			dmdc_pkg::ST_LOAD_EMIT: if (obuf_free) state_d = dmdc_pkg::ST_IDLE;
			default: state_d = dmdc_pkg::ST_IDLE;
		endcase
	end

	// memory control and result generation
	logic        emit;
	logic [1:0]  e_kind;
	logic [31:0] e_addr, e_word;
	logic [63:0] e_load;
	logic        e_last;
	always_comb begin
		tag_we = 1'b0;
		tag_wa = line;
		tag_wd = '0;
		tag_ra = address[LW+3:4];
		dat_we = 1'b0;
		dat_wa = {line, addr_q[3]};
		dat_wd = '0;
		dat_ra = {line, addr_q[3]};
		emit = 1'b0;
		e_kind = dmdc_pkg::KIND_LOAD;
		e_addr = '0;
		e_word = '0;
		e_load = '0;
		e_last = 1'b0;
		unique case (state_q)
			dmdc_pkg::ST_CLEAR: begin
				tag_we = 1'b1;
				tag_wa = clr_q;
			end
			dmdc_pkg::ST_LOOKUP: begin
				if (!hit) begin
					tag_we = 1'b1;
					tag_wd = {1'b1, op_q == dmdc_pkg::OP_STORE, addr_q[31:12]};
				end
			end
			dmdc_pkg::ST_WB_RD: dat_ra = {line, cnt_q[1]};
			dmdc_pkg::ST_WB_EMIT: begin
				// keep the victim pair on the read port for both of its words
				dat_ra = {line, cnt_q[1]};
				emit = 1'b1;
				e_kind = dmdc_pkg::KIND_WRITE;
				e_addr = {old_tag_q, 12'd0} | (32'(line) << 4) | {28'd0, cnt_q, 2'b00};
				e_word = cnt_q[0] ? dat_rd[31:0] : dat_rd[63:32];
			end
			dmdc_pkg::ST_REQ: begin
				emit = 1'b1;
				e_kind = dmdc_pkg::KIND_READ;
				e_addr = {addr_q[31:12], 12'd0} | (32'(line) << 4) | {28'd0, rq_word, 2'b00};
				e_last = (pos_q == 2'd3);
			end
			dmdc_pkg::ST_WAIT_FILL: dat_ra = {line, fword[1]};
			dmdc_pkg::ST_FILL_WR: begin
				dat_we = 1'b1;
				dat_wa = {line, fword[1]};
				dat_wd = fword[0] ? {dat_rd[63:32], fw_q} : {fw_q, dat_rd[31:0]};
			end
			dmdc_pkg::ST_FIN_WR: begin
				dat_we = 1'b1;
				dat_wd = dmdc_pkg::merge(dat_rd, size_q, addr_q[2:0], sv_q);
				// a store always leaves the line dirty
				tag_we = 1'b1;
				tag_wd = {1'b1, 1'b1, addr_q[31:12]};
			end
			dmdc_pkg::ST_LOAD_EMIT: begin
				emit = 1'b1;
				e_load = dmdc_pkg::extract(dat_rd, size_q, addr_q[2:0]);
				e_last = 1'b1;
			end
			default: ;
		endcase
	end

	// hold data-store read data (load or write-back) across a stalled output
	logic [63:0] dat_hold_q;
	logic        hold_v_q;
	logic [63:0] dat_eff;
	assign dat_eff = hold_v_q ? dat_hold_q : dat_rd;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dmdc_pkg::ST_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			fills_q <= '0;
			out_valid <= 1'b0;
			pend_q <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dmdc_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (emit && obuf_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			hold_v_q <= (state_q == dmdc_pkg::ST_WB_EMIT || state_q == dmdc_pkg::ST_LOAD_EMIT)
				&& !obuf_free;
			if (state_q == dmdc_pkg::ST_LOOKUP) begin
				cnt_q <= '0;
				pos_q <= is_dbl_store ? 2'd2 : 2'd0;
				fills_q <= is_dbl_store ? 3'd2 : 3'd4;
				pend_q <= !hit;
			end
			if (state_q == dmdc_pkg::ST_WB_EMIT && obuf_free) cnt_q <= cnt_q + 1'b1;
			if (state_q == dmdc_pkg::ST_REQ && obuf_free) pos_q <= pos_q + 1'b1;
			if (state_q == dmdc_pkg::ST_FILL_WR) fills_q <= fills_q - 1'b1;
			if (state_q == dmdc_pkg::ST_FIN_WR || state_q == dmdc_pkg::ST_LOAD_EMIT)
				pend_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc && state_q == dmdc_pkg::ST_IDLE) begin
			op_q <= opcode;
			size_q <= access_size;
			addr_q <= address;
			sv_q <= store_value;
		end
		if (acc) fw_q <= fill_word;
		if (state_q == dmdc_pkg::ST_LOOKUP) old_tag_q <= t_tag;
		if (!hold_v_q) dat_hold_q <= dat_rd;
		if (emit && obuf_free) begin
			kind <= e_kind;
			bus_address <= e_addr;
			bus_word <= (state_q == dmdc_pkg::ST_WB_EMIT)
				? (cnt_q[0] ? dat_eff[31:0] : dat_eff[63:32]) : e_word;
			load_value <= (state_q == dmdc_pkg::ST_LOAD_EMIT)
				? dmdc_pkg::extract(dat_eff, size_q, addr_q[2:0]) : e_load;
			last <= e_last;
		end
	end

	// checks
	`ASSERT_NEVER(a_no_accept_clear, clk, arst_n,
		in_ready && state_q == dmdc_pkg::ST_CLEAR, "item accepted during clear")
	`ASSERT_IMPL(a_fill_range, clk, arst_n, fills_q <= 3'd4, "fill count out of range")
	`ASSERT_IMPL(a_emit_busy, clk, arst_n,
		(out_valid && !out_ready) |=> out_valid, "result dropped while stalled")
	`ASSERT_NEVER(a_pend_idle, clk, arst_n,
		state_q == dmdc_pkg::ST_WAIT_FILL && !pend_q, "waiting for fill with none pending")
endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the direct-mapped write-back data cache.
// Depends on dmdc_pkg and direct_mapped_writeback_dcache_top.
module testbench;
	localparam int LINES = 512;
	localparam int RANDOM_ITEMS = 390;

	// short names for the item codes
	localparam logic [1:0] T_LOAD   = dmdc_pkg::OP_LOAD;
	localparam logic [1:0] T_STORE  = dmdc_pkg::OP_STORE;
	localparam logic [1:0] T_FILL   = dmdc_pkg::OP_FILL;
	localparam logic [1:0] T_UNUSED = 2'd3;
	localparam logic [1:0] S_BYTE = dmdc_pkg::SZ_BYTE;
	localparam logic [1:0] S_HALF = dmdc_pkg::SZ_HALF;
	localparam logic [1:0] S_WORD = dmdc_pkg::SZ_WORD;
	localparam logic [1:0] S_DBL  = dmdc_pkg::SZ_DBL;

	typedef enum logic [1:0] {MISS_NONE, MISS_LOAD, MISS_STORE} miss_kind_t;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] bus_address;
		logic [31:0] bus_word;
		logic [63:0] load_value;
		logic        last;
	} cache_result_t;

	typedef struct {
		logic [1:0]  op;
		logic [1:0]  size;
		logic [31:0] addr;
		logic [63:0] data;
		logic [31:0] fill;
		bit          has_load;
		logic [63:0] load_exp;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = T_LOAD;
	logic [1:0]  access_size = S_BYTE;
	logic [31:0] address = '0;
	logic [63:0] store_value = '0;
	logic [31:0] fill_word = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [31:0] bus_address;
	logic [31:0] bus_word;
	logic [63:0] load_value;
	logic        last;

	// predictor copy of the cache state
	logic [31:0] cache_words [LINES*4];
	logic [19:0] cache_tags [LINES];
	bit          cache_valid [LINES];
	bit          cache_dirty [LINES];
	miss_kind_t  miss_kind = MISS_NONE;
	logic [1:0]  miss_size = '0;
	logic [31:0] miss_addr = '0;
	logic [63:0] miss_data = '0;
	int          fills_left = 0;

	cache_result_t expected_results[$];
	int errors = 0;
	int items_in = 0;

	// directed items; load values typed where they read off at a glance
	dir_row_t dir_rows[26] = '{
		'{T_LOAD,  S_BYTE, 32'h0000_1000, 64'd0, 32'd0, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h1122_3344, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h5566_7788, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h99aa_bbcc, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'hddee_ff00, 1'b1, 64'h11},
		'{T_LOAD,  S_HALF, 32'h0000_1002, 64'd0, 32'd0, 1'b1, 64'h3344},
		'{T_LOAD,  S_WORD, 32'h0000_1004, 64'd0, 32'd0, 1'b1, 64'h5566_7788},
		'{T_LOAD,  S_DBL,  32'h0000_1008, 64'd0, 32'd0, 1'b1, 64'h99aa_bbcc_ddee_ff00},
		'{T_STORE, S_BYTE, 32'h0000_1003, 64'hffff_ffff_ffff_ffab, 32'd0, 1'b0, 64'd0},
		'{T_STORE, S_DBL,  32'h0000_1008, 64'hffff_ffff_ffff_ffff, 32'd0, 1'b0, 64'd0},
		'{T_LOAD,  S_DBL,  32'h0000_1000, 64'd0, 32'd0, 1'b1, 64'h1122_33ab_5566_7788},
		'{T_LOAD,  S_BYTE, 32'hffff_ffff, 64'd0, 32'd0, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'hffff_ffff, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h0000_00a5, 1'b0, 64'd0},
		'{T_LOAD,  S_WORD, 32'h0000_1000, 64'd0, 32'd0, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'd0, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'd0, 1'b1, 64'ha5},
		'{T_STORE, S_DBL,  32'h0000_2008, 64'h0123_4567_89ab_cdef, 32'd0, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'hcafe_0001, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'hcafe_0002, 1'b0, 64'd0},
		'{T_LOAD,  S_WORD, 32'h0000_3000, 64'd0, 32'd0, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h0bad_0000, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h0bad_0001, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h0bad_0002, 1'b0, 64'd0},
		'{T_FILL,  S_BYTE, 32'd0, 64'd0, 32'h0bad_0003, 1'b1, 64'h0bad_0000},
		'{T_UNUSED, S_DBL, 32'hffff_fff0, 64'd0, 32'hffff_ffff, 1'b0, 64'd0}
	};

	direct_mapped_writeback_dcache_top dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [31:0] word_address(int ln, int w);
		return {cache_tags[ln], 12'd0} | (32'(ln) << 4) | (32'(w) << 2);
	endfunction

	function automatic logic [63:0] lane_read(int ln, logic [1:0] size, logic [31:0] a);
		logic [31:0] w;
		int hi;
		w = cache_words[ln*4 + a[3:2]];
		hi = ln*4 + {a[3], 1'b0};
		case (size)
			S_BYTE: return 64'((w >> ((3 - a[1:0]) * 8)) & 32'hff);
			S_HALF: return 64'((w >> (a[1] ? 0 : 16)) & 32'hffff);
			S_WORD: return 64'(w);
			default: return {cache_words[hi], cache_words[hi+1]};
		endcase
	endfunction

	function automatic void lane_write(int ln, logic [1:0] size, logic [31:0] a,
			logic [63:0] v);
		int idx;
		int sh;
		idx = ln*4 + a[3:2];
		case (size)
			S_BYTE: begin
				sh = (3 - a[1:0]) * 8;
				cache_words[idx] = (cache_words[idx] & ~(32'hff << sh)) | (32'(v[7:0]) << sh);
			end
			S_HALF: begin
				sh = a[1] ? 0 : 16;
				cache_words[idx] = (cache_words[idx] & ~(32'hffff << sh)) |
					(32'(v[15:0]) << sh);
			end
			S_WORD: cache_words[idx] = v[31:0];
			default: begin
				idx = ln*4 + {a[3], 1'b0};
				cache_words[idx] = v[63:32];
				cache_words[idx+1] = v[31:0];
			end
		endcase
	endfunction

	function automatic void push_result(logic [1:0] k, logic [31:0] ba, logic [31:0] bw,
			logic [63:0] lv);
		cache_result_t r;
		r = '{k, ba, bw, lv, 1'b0};
		expected_results.push_back(r);
	endfunction

	// advance the cache model by one item; return 1 when it was not ignored
	function automatic bit predict_access(logic [1:0] op, logic [1:0] size, logic [31:0] a,
			logic [63:0] sv, logic [31:0] fw);
		int n0;
		int ln;
		int total;
		int pos;
		int first;
		bit used;
		n0 = expected_results.size();
		used = 1'b0;
		if (op == T_FILL) begin
			if (miss_kind != MISS_NONE && fills_left != 0) begin
				used = 1'b1;
				ln = miss_addr[12:4];
				total = (miss_kind == MISS_STORE && miss_size == S_DBL) ? 2 : 4;
				pos = total - fills_left;
				if (total == 2) pos += 2;
				cache_words[ln*4 + {pos[1] ^ miss_addr[3], pos[0]}] = fw;
				fills_left--;
				if (fills_left == 0) begin
					if (miss_kind == MISS_STORE) lane_write(ln, miss_size, miss_addr, miss_data);
					else push_result(dmdc_pkg::KIND_LOAD, '0, '0,
						lane_read(ln, miss_size, miss_addr));
					miss_kind = MISS_NONE;
				end
			end
		end else if ((op == T_LOAD || op == T_STORE) && miss_kind == MISS_NONE) begin
			used = 1'b1;
			ln = a[12:4];
			if (cache_valid[ln] && cache_tags[ln] == a[31:12]) begin
				if (op == T_LOAD) push_result(dmdc_pkg::KIND_LOAD, '0, '0, lane_read(ln, size, a));
				else begin
					lane_write(ln, size, a, sv);
					cache_dirty[ln] = 1'b1;
				end
			end else begin
				if (cache_dirty[ln])
					for (int w = 0; w < 4; w++)
						push_result(dmdc_pkg::KIND_WRITE, word_address(ln, w),
							cache_words[ln*4 + w], '0);
				cache_tags[ln] = a[31:12];
				cache_valid[ln] = 1'b1;
				cache_dirty[ln] = (op == T_STORE);
				first = (op == T_STORE && size == S_DBL) ? 2 : 0;
				for (int p = first; p < 4; p++)
					push_result(dmdc_pkg::KIND_READ, word_address(ln, {p[1] ^ a[3], p[0]}),
						'0, '0);
				miss_kind = (op == T_STORE) ? MISS_STORE : MISS_LOAD;
				miss_size = size;
				miss_addr = a;
				miss_data = sv;
				fills_left = 4 - first;
			end
		end
		if (expected_results.size() > n0)
			expected_results[expected_results.size()-1].last = 1'b1;
		return used;
	endfunction

	// compare each result item with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result kind=%0d addr=%h word=%h load=%h last=%b",
					$time, kind, bus_address, bus_word, load_value, last);
				errors++;
			end else begin
				cache_result_t e;
				e = expected_results.pop_front();
				if (kind !== e.kind) begin
					$display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
					errors++;
				end
				if (bus_address !== e.bus_address) begin
					$display("%0t: bus_address expected %h actual %h", $time, e.bus_address,
						bus_address);
					errors++;
				end
				if (bus_word !== e.bus_word) begin
					$display("%0t: bus_word expected %h actual %h", $time, e.bus_word, bus_word);
					errors++;
				end
				if (load_value !== e.load_value) begin
					$display("%0t: load_value expected %h actual %h", $time, e.load_value,
						load_value);
					errors++;
				end
				if (last !== e.last) begin
					$display("%0t: last expected %b actual %b", $time, e.last, last);
					errors++;
				end
			end
		end
	end

	// receiver: ready runs and random stalls, plus one long hold-off
	initial begin
		int cyc;
		bit held;
		cyc = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && items_in >= 100) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end else
				out_ready <= (cyc % 128 < 48) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	int burst_left = 0;

	// offer one item; valid stays high through bursts, drops in gaps
	task automatic send_item(logic [1:0] op, logic [1:0] size, logic [31:0] a,
			logic [63:0] sv, logic [31:0] fw, output bit used);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode <= op;
		access_size <= size;
		address <= a;
		store_value <= sv;
		fill_word <= fw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		used = predict_access(op, size, a, sv, fw);
		items_in++;
	endtask

	function automatic logic [31:0] pick_address();
		logic [19:0] tg;
		logic [7:0] ln;
		case ($urandom_range(0, 4))
			0: tg = 20'h00000;
			1: tg = 20'h00001;
			2: tg = 20'hfffff;
			3: tg = 20'h00002;
			default: tg = 20'($urandom);
		endcase
		case ($urandom_range(0, 3))
			0: ln = 8'h00;
			1: ln = 8'h01;
			2: ln = 8'hff;
			default: ln = 8'($urandom);
		endcase
		return {tg, ln, 4'($urandom)};
	endfunction

	initial begin
		bit used;
		int effective;
		logic [63:0] sv;
		for (int i = 0; i < LINES*4; i++) cache_words[i] = '0;
		for (int i = 0; i < LINES; i++) begin
			cache_tags[i] = '0;
			cache_valid[i] = 1'b0;
			cache_dirty[i] = 1'b0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].op, dir_rows[i].size, dir_rows[i].addr, dir_rows[i].data,
				dir_rows[i].fill, used);
			if (dir_rows[i].has_load && (expected_results.size() == 0 ||
					expected_results[expected_results.size()-1].load_value
					!== dir_rows[i].load_exp)) begin
				$display("%0t: directed row %0d load expected %h", $time, i,
					dir_rows[i].load_exp);
				errors++;
			end
		end

		// mostly well-formed access and fill sequences, some noise
		effective = 0;
		while (effective < RANDOM_ITEMS) begin
			sv = {$urandom, $urandom};
			if (miss_kind != MISS_NONE) begin
				if ($urandom_range(0, 9) != 0)
					send_item(T_FILL, 2'($urandom), $urandom, sv, $urandom, used);
				else
					send_item(2'($urandom_range(0, 1)) | ($urandom_range(0, 3) == 0 ? T_UNUSED
						: T_LOAD), 2'($urandom), pick_address(), sv, $urandom, used);
			end else if ($urandom_range(0, 7) != 0)
				send_item(2'($urandom_range(T_LOAD, T_STORE)), 2'($urandom), pick_address(),
					sv, $urandom, used);
			else
				send_item($urandom_range(0, 1) ? T_FILL : T_UNUSED, 2'($urandom), $urandom, sv,
					$urandom, used);
			if (used) effective++;
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
